/* design/tcsp_pkg.sv */
// tcsp_pkg: register indexes and fixed widths of the truncated cone support block
// no dependencies; imported by the top level
`default_nettype none

package tcsp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RADIUS_W   = 31;
  localparam int SINE_W     = 18;
  localparam int EPS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RADIUS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SINE          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON       = 3'd5;

  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

endpackage

`default_nettype wire

/* design/tcsp_isqrt2.sv */
// tcsp_isqrt2: two floor square roots, one result bit per pipeline stage
// standalone; a tag word travels alongside each beat
`default_nettype none

module tcsp_isqrt2 #(
  parameter int RW = 32,
  parameter int TW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  input  wire logic [2*RW-1:0]   rad_a,
  input  wire logic [2*RW-1:0]   rad_b,
  input  wire logic [TW-1:0]     in_tag,
  output logic                   out_vld,
  output logic [RW-1:0]          root_a,
  output logic [RW-1:0]          root_b,
  output logic [TW-1:0]          out_tag
);

  localparam int NW  = 2 * RW;
  localparam int RMW = RW + 2;

  logic            vld_q [1:RW];
  logic [NW-1:0]   rada_q [1:RW];
  logic [NW-1:0]   radb_q [1:RW];
  logic [RMW-1:0]  rema_q [1:RW];
  logic [RMW-1:0]  remb_q [1:RW];
  logic [RW-1:0]   rta_q [1:RW];
  logic [RW-1:0]   rtb_q [1:RW];
  logic [TW-1:0]   tag_q [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           v_in;
    logic [NW-1:0]  ra_in, rb_in;
    logic [RMW-1:0] ma_in, mb_in, ta, tb, tra, trb;
    logic [RW-1:0]  qa_in, qb_in;
    logic [TW-1:0]  tg_in;

    if (k == 0) begin : g_first
      assign v_in  = in_vld;
      assign ra_in = rad_a;
      assign rb_in = rad_b;
      assign ma_in = '0;
      assign mb_in = '0;
      assign qa_in = '0;
      assign qb_in = '0;
      assign tg_in = in_tag;
    end else begin : g_next
      assign v_in  = vld_q[k];
      assign ra_in = rada_q[k];
      assign rb_in = radb_q[k];
      assign ma_in = rema_q[k];
      assign mb_in = remb_q[k];
      assign qa_in = rta_q[k];
      assign qb_in = rtb_q[k];
      assign tg_in = tag_q[k];
    end

    // bring down the next two radicand bits and try root*4+1
    assign ta  = {ma_in[RMW-3:0], ra_in[NW-1:NW-2]};
    assign tb  = {mb_in[RMW-3:0], rb_in[NW-1:NW-2]};
    assign tra = {qa_in, 2'b01};
    assign trb = {qb_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= v_in;
      end
      rada_q[k+1] <= ra_in << 2;
      radb_q[k+1] <= rb_in << 2;
      tag_q[k+1]  <= tg_in;
      if (ta >= tra) begin
        rema_q[k+1] <= ta - tra;
        rta_q[k+1]  <= {qa_in[RW-2:0], 1'b1};
      end else begin
        rema_q[k+1] <= ta;
        rta_q[k+1]  <= {qa_in[RW-2:0], 1'b0};
      end
      if (tb >= trb) begin
        remb_q[k+1] <= tb - trb;
        rtb_q[k+1]  <= {qb_in[RW-2:0], 1'b1};
      end else begin
        remb_q[k+1] <= tb;
        rtb_q[k+1]  <= {qb_in[RW-2:0], 1'b0};
      end
    end
  end

  assign out_vld = vld_q[RW];
  assign root_a  = rta_q[RW];
  assign root_b  = rtb_q[RW];
  assign out_tag = tag_q[RW];

endmodule

`default_nettype wire

/* design/tcsp_div2.sv */
// tcsp_div2: two unsigned dividers sharing a divisor, one quotient bit per stage
// standalone; flags quotients that do not fit in QW bits; tag travels alongside
`default_nettype none

module tcsp_div2 #(
  parameter int NUMW = 63,
  parameter int QW   = 32,
  parameter int TW   = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire logic [NUMW-1:0] num_a,
  input  wire logic [NUMW-1:0] num_b,
  input  wire logic [QW-1:0]   den,
  input  wire logic [TW-1:0]   in_tag,
  output logic                 out_vld,
  output logic [QW-1:0]        quot_a,
  output logic [QW-1:0]        quot_b,
  output logic                 ovf_a,
  output logic                 ovf_b,
  output logic [TW-1:0]        out_tag
);

  localparam int HW = NUMW - QW;
  localparam int CW = (HW > QW) ? HW : QW;

  logic [HW-1:0] hi_a, hi_b;
  logic          ovf0_a, ovf0_b;

  // quotient overflows QW bits exactly when the high part reaches the divisor
  assign hi_a   = num_a[NUMW-1:QW];
  assign hi_b   = num_b[NUMW-1:QW];
  assign ovf0_a = CW'(hi_a) >= CW'(den);
  assign ovf0_b = CW'(hi_b) >= CW'(den);

  logic          vld_q [1:QW];
  logic [QW-1:0] den_q [1:QW];
  logic [QW-1:0] loa_q [1:QW];
  logic [QW-1:0] lob_q [1:QW];
  logic [QW-1:0] rema_q [1:QW];
  logic [QW-1:0] remb_q [1:QW];
  logic [QW-1:0] qa_q [1:QW];
  logic [QW-1:0] qb_q [1:QW];
  logic          ova_q [1:QW];
  logic          ovb_q [1:QW];
  logic [TW-1:0] tag_q [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          v_in, oa_in, ob_in;
    logic [QW-1:0] d_in, la_in, lb_in, ma_in, mb_in, qa_in, qb_in;
    logic [TW-1:0] tg_in;
    logic [QW:0]   ta, tb;
    logic          ga, gb;

    if (k == 0) begin : g_first
      assign v_in  = in_vld;
      assign d_in  = den;
      assign la_in = num_a[QW-1:0];
      assign lb_in = num_b[QW-1:0];
      assign ma_in = QW'(hi_a);
      assign mb_in = QW'(hi_b);
      assign qa_in = '0;
      assign qb_in = '0;
      assign oa_in = ovf0_a;
      assign ob_in = ovf0_b;
      assign tg_in = in_tag;
    end else begin : g_next
      assign v_in  = vld_q[k];
      assign d_in  = den_q[k];
      assign la_in = loa_q[k];
      assign lb_in = lob_q[k];
      assign ma_in = rema_q[k];
      assign mb_in = remb_q[k];
      assign qa_in = qa_q[k];
      assign qb_in = qb_q[k];
      assign oa_in = ova_q[k];
      assign ob_in = ovb_q[k];
      assign tg_in = tag_q[k];
    end

    assign ta = {ma_in, la_in[QW-1]};
    assign tb = {mb_in, lb_in[QW-1]};
    assign ga = ta >= {1'b0, d_in};
    assign gb = tb >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= v_in;
      end
      den_q[k+1]  <= d_in;
      loa_q[k+1]  <= la_in << 1;
      lob_q[k+1]  <= lb_in << 1;
      ova_q[k+1]  <= oa_in;
      ovb_q[k+1]  <= ob_in;
      tag_q[k+1]  <= tg_in;
      rema_q[k+1] <= ga ? QW'(ta - {1'b0, d_in}) : QW'(ta);
      remb_q[k+1] <= gb ? QW'(tb - {1'b0, d_in}) : QW'(tb);
      qa_q[k+1]   <= {qa_in[QW-2:0], ga};
      qb_q[k+1]   <= {qb_in[QW-2:0], gb};
    end
  end

  assign out_vld = vld_q[QW];
  assign quot_a  = qa_q[QW];
  assign quot_b  = qb_q[QW];
  assign ovf_a   = ova_q[QW];
  assign ovf_b   = ovb_q[QW];
  assign out_tag = tag_q[QW];

endmodule

`default_nettype wire

/* design/truncated_cone_support_point.sv */
// Support point of a truncated cone for GJK queries, signed Q16.16 fixed point.
// A direction is taken in any cycle that start is high and busy is low (busy is
// high only in reset); the support point appears on point_x/y/z with done high
// for one cycle, computed at an internal width of DATA_WIDTH capped at 32. The
// latency comes from the bit-per-stage square root and the bit-per-stage rim
// divider; a new direction enters every cycle and the result side cannot stall.
// The user must write shape registers through the cfg port only while no
// direction is in flight; the block itself does not enforce this.
// depends on tcsp_pkg, tcsp_isqrt2, tcsp_div2
`default_nettype none

module truncated_cone_support_point import tcsp_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [DATA_WIDTH-1:0] vec_x,
  input  wire logic signed [DATA_WIDTH-1:0] vec_y,
  input  wire logic signed [DATA_WIDTH-1:0] vec_z,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                              done,
  output logic signed [DATA_WIDTH-1:0]      point_x,
  output logic signed [DATA_WIDTH-1:0]      point_y,
  output logic signed [DATA_WIDTH-1:0]      point_z
);

  localparam int EW  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int SQW = 2 * EW;
  localparam int PW  = EW + RADIUS_W;
  localparam int LW  = EW + SINE_W + 1;
  localparam logic [EW-1:0] WMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] WMIN = {1'b1, {(EW-1){1'b0}}};

  typedef struct packed {
    logic signed [EW-1:0] x;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic          zero;
    logic          neg_x;
    logic          neg_z;
    logic [EW-1:0] py;
  } rim_t;

  // shape registers
  logic [RADIUS_W-1:0]      bottom_radius, top_radius, bottom_height, top_height;
  logic signed [SINE_W-1:0] sine_half_angle;
  logic [EPS_W-1:0]         epsilon;

  assign busy      = rst;
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_radius   <= '0;
      top_radius      <= '0;
      bottom_height   <= '0;
      top_height      <= '0;
      sine_half_angle <= '0;
      epsilon         <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOTTOM_RADIUS: bottom_radius   <= cfg_data[RADIUS_W-1:0];
        REG_TOP_RADIUS:    top_radius      <= cfg_data[RADIUS_W-1:0];
        REG_BOTTOM_HEIGHT: bottom_height   <= cfg_data[RADIUS_W-1:0];
        REG_TOP_HEIGHT:    top_height      <= cfg_data[RADIUS_W-1:0];
        REG_SINE:          sine_half_angle <= cfg_data[SINE_W-1:0];
        REG_EPSILON:       epsilon         <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture
  logic v1;
  vec_t d1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    d1.x <= vec_x[EW-1:0];
    d1.y <= vec_y[EW-1:0];
    d1.z <= vec_z[EW-1:0];
  end

  // stage 2: squares of the magnitudes
  logic [EW-1:0]  mx1, my1, mz1;
  logic           v2;
  vec_t           d2;
  logic [SQW-1:0] sqx2, sqy2, sqz2;

  assign mx1 = d1.x[EW-1] ? EW'(-d1.x) : EW'(d1.x);
  assign my1 = d1.y[EW-1] ? EW'(-d1.y) : EW'(d1.y);
  assign mz1 = d1.z[EW-1] ? EW'(-d1.z) : EW'(d1.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    d2   <= d1;
    sqx2 <= mx1 * mx1;
    sqy2 <= my1 * my1;
    sqz2 <= mz1 * mz1;
  end

  // stages 3 and 4: planar and full sums of squares
  logic           v3, v4;
  vec_t           d3, d4;
  logic [SQW-1:0] sxz3, sqy3, sxz4, sn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= v2;
      v4 <= v3;
    end
    d3   <= d2;
    sxz3 <= sqx2 + sqz2;
    sqy3 <= sqy2;
    d4   <= d3;
    sxz4 <= sxz3;
    sn4  <= sxz3 + sqy3;
  end

  // square roots: norm and planar length
  logic          v5;
  logic [EW-1:0] norm5, s5;
  vec_t          d5;

  tcsp_isqrt2 #(
    .RW (EW),
    .TW ($bits(vec_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v4),
    .rad_a   (sn4),
    .rad_b   (sxz4),
    .in_tag  (d4),
    .out_vld (v5),
    .root_a  (norm5),
    .root_b  (s5),
    .out_tag (d5)
  );

  // stage 6: cone angle products and length tests
  logic                 v6, null6, axis6;
  vec_t                 d6;
  logic [EW-1:0]        s6;
  logic signed [LW-1:0] lhs6, rhs6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    d6    <= d5;
    s6    <= s5;
    null6 <= norm5 <= EW'(epsilon);
    axis6 <= s5 <= EW'(epsilon);
    lhs6  <= LW'(d5.y) <<< 16;
    rhs6  <= LW'($signed({1'b0, norm5})) * LW'(sine_half_angle);
  end

  // stage 7: pick rim, axial coordinate
  logic                top6;
  logic signed [32:0]  pyw6;
  logic [EW-1:0]       pys6, mx6, mz6;
  logic                v7;
  rim_t                r7;
  logic [RADIUS_W-1:0] rad7;
  logic [EW-1:0]       mx7, mz7, s7;

  assign top6 = lhs6 > rhs6;
  assign mx6  = d6.x[EW-1] ? EW'(-d6.x) : EW'(d6.x);
  assign mz6  = d6.z[EW-1] ? EW'(-d6.z) : EW'(d6.z);

  always_comb begin
    priority if (null6) begin
      pyw6 = '0;
    end else if (axis6) begin
      pyw6 = d6.y[EW-1] ? -$signed({2'b00, bottom_height}) : $signed({2'b00, top_height});
    end else begin
      pyw6 = top6 ? $signed({2'b00, top_height}) : -$signed({2'b00, bottom_height});
    end
    priority if (pyw6 > $signed(33'(WMAX))) begin
      pys6 = WMAX;
    end else if (pyw6 < -$signed(33'(WMAX)) - 33'sd1) begin
      pys6 = WMIN;
    end else begin
      pys6 = pyw6[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    r7.zero  <= null6 || axis6;
    r7.neg_x <= d6.x[EW-1];
    r7.neg_z <= d6.z[EW-1];
    r7.py    <= pys6;
    rad7     <= top6 ? top_radius : bottom_radius;
    mx7      <= mx6;
    mz7      <= mz6;
    s7       <= s6;
  end

  // stage 8: scale by radius
  logic          v8;
  rim_t          r8;
  logic [PW-1:0] prx8, prz8;
  logic [EW-1:0] s8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    r8   <= r7;
    s8   <= s7;
    prx8 <= mx7 * rad7;
    prz8 <= mz7 * rad7;
  end

  // divide by planar length
  logic          v9, ovx9, ovz9;
  logic [EW-1:0] qx9, qz9;
  rim_t          r9;

  tcsp_div2 #(
    .NUMW (PW),
    .QW   (EW),
    .TW   ($bits(rim_t))
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v8),
    .num_a   (prx8),
    .num_b   (prz8),
    .den     (s8),
    .in_tag  (r8),
    .out_vld (v9),
    .quot_a  (qx9),
    .quot_b  (qz9),
    .ovf_a   (ovx9),
    .ovf_b   (ovz9),
    .out_tag (r9)
  );

  // sign and saturation of the rim coordinates
  function automatic logic [EW-1:0] rim_sat(input logic neg, input logic ovf,
                                           input logic [EW-1:0] q);
    logic [EW-1:0] r;
    if (neg) begin
      r = (ovf || q > WMIN) ? WMIN : EW'(-q);
    end else begin
      r = (ovf || q[EW-1]) ? WMAX : q;
    end
    return r;
  endfunction

  logic [EW-1:0] px9, pz9;

  assign px9 = r9.zero ? '0 : rim_sat(r9.neg_x, ovx9, qx9);
  assign pz9 = r9.zero ? '0 : rim_sat(r9.neg_z, ovz9, qz9);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
    point_x <= DATA_WIDTH'(px9);
    point_y <= DATA_WIDTH'(r9.py);
    point_z <= DATA_WIDTH'(pz9);
  end

endmodule

`default_nettype wire
